// ===== src/mmed_pkg.sv =====
// Shared types, constants and codes of the min/max envelope decimator.
package mmed_pkg;

    // Sample format and frame limits
    localparam int SAMPLE_WIDTH      = 16;
    localparam int MAX_FRAME_SAMPLES = 1048576;
    localparam int MAX_COLUMNS       = 4096;

    // Field and register widths
    localparam int START_W = 20;
    localparam int LEN_W   = 21;
    localparam int COLS_W  = 13;
    localparam int COL_W   = 21;
    localparam int IDX_W   = 21;
    localparam int CFG_W   = 21;
    localparam int SUM_W   = 22;

    // Divider iterations: one quotient bit per cycle
    localparam int DIV_STEPS = LEN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WINDOW_START    = 2'd0,
        CFG_WINDOW_LENGTH   = 2'd1,
        CFG_DISPLAY_WIDTH   = 2'd2,
        CFG_DECIMATE_ENABLE = 2'd3
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PROCESS
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [LEN_W-1:0]  dividend;
        logic [COLS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/mmed_sample_if.sv =====
// Input channel: one signal sample per request.
interface mmed_sample_if;
    import mmed_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    frame_start;

    modport source (output valid, output sample, output frame_start, input ready);
    modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

// ===== src/mmed_result_if.sv =====
// Output channel: one envelope column or pass-through point per request.
interface mmed_result_if;
    import mmed_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    sample_t          high_value;
    sample_t          low_value;
    logic             envelope_mode;
    logic             last;

    modport source (output valid, output column, output high_value, output low_value,
                    output envelope_mode, output last, input ready);
    modport sink   (input valid, input column, input high_value, input low_value,
                    input envelope_mode, input last, output ready);
endinterface

// ===== src/mmed_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bucket length.
module mmed_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mmed_pkg::div_req_t req,
    output mmed_pkg::div_rsp_t rsp
);
    import mmed_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]     quo_reg, quo_next;
    logic [COLS_W-1:0]    rem_reg, rem_next;
    logic [COLS_W-1:0]    dsr_reg, dsr_next;

    logic [COLS_W:0]      rem_shift;
    logic [COLS_W:0]      rem_diff;
    logic                 fits;

    // One trial subtraction
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[LEN_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
    end

    // Step control
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            quo_next   = req.dividend;
            rem_next   = '0;
            dsr_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[LEN_W-2:0], fits};
            rem_next   = fits ? rem_diff[COLS_W-1:0] : rem_shift[COLS_W-1:0];
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/min_max_envelope_decimator.sv =====
// Min/max envelope decimator: reduces a sample frame to display columns or points.
//
// Each sample request is taken in the idle state and worked on in the following cycle;
// no new request is taken until that work is done, and the work waits while the result
// register is still held by the downstream side. A frame_start sample that selects
// envelope mode first runs the bucket-length division on the restoring divider, one
// quotient bit per cycle, and is worked on once the quotient is ready.
// Configuration written at any time takes effect at the next frame_start.
module min_max_envelope_decimator (
    input  logic                     clk,
    input  logic                     rst_n,
    mmed_sample_if.sink              samples,
    mmed_result_if.source            results,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [mmed_pkg::CFG_W-1:0] cfg_data
);
    import mmed_pkg::*;

    // Configuration registers
    logic [START_W-1:0] window_start_reg;
    logic [LEN_W-1:0]   window_length_reg;
    logic [COLS_W-1:0]  display_width_reg;
    logic               decimate_enable_reg;

    // Sequencer and frame state
    state_t             state_reg, state_next;
    logic               frame_open_reg, frame_open_next;
    logic               env_active_reg, env_active_next;
    logic [START_W-1:0] f_start_reg, f_start_next;
    logic [LEN_W-1:0]   f_len_reg, f_len_next;
    logic [COLS_W-1:0]  f_cols_reg, f_cols_next;
    logic [LEN_W-1:0]   bucket_length_reg, bucket_length_next;
    logic [LEN_W-1:0]   bucket_count_reg, bucket_count_next;
    logic [COLS_W-1:0]  column_index_reg, column_index_next;
    logic [IDX_W-1:0]   sample_index_reg, sample_index_next;
    sample_t            running_max_reg, running_max_next;
    sample_t            running_min_reg, running_min_next;
    sample_t            sample_reg, sample_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [COL_W-1:0]   out_column_reg, out_column_next;
    sample_t            out_high_reg, out_high_next;
    sample_t            out_low_reg, out_low_next;
    logic               out_env_reg, out_env_next;
    logic               out_last_reg, out_last_next;

    // Working signals
    logic               accept;
    logic [COLS_W-1:0]  cols_cfg;
    logic [COLS_W+2:0]  five_cols;
    logic               env_pick;
    logic               in_frame;
    logic [SUM_W-1:0]   idx_ext;
    logic [SUM_W-1:0]   start_ext;
    logic [SUM_W-1:0]   pass_end;
    logic [SUM_W-1:0]   win_end;
    logic               in_env_win;
    logic               in_pass_win;
    sample_t            max_upd;
    sample_t            min_upd;
    logic [LEN_W-1:0]   count_upd;
    logic               more_cols;
    logic               emit;
    logic               stall;
    logic [COL_W-1:0]   emit_column;
    sample_t            emit_high;
    sample_t            emit_low;
    logic               emit_env;
    logic               emit_last;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign accept = samples.valid && samples.ready;

    // Divider for the bucket length
    mmed_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg    <= '0;
            window_length_reg   <= LEN_W'(1);
            display_width_reg   <= COLS_W'(1);
            decimate_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_START:    window_start_reg    <= cfg_data[START_W-1:0];
                CFG_WINDOW_LENGTH:   window_length_reg   <= cfg_data[LEN_W-1:0];
                CFG_DISPLAY_WIDTH:   display_width_reg   <= cfg_data[COLS_W-1:0];
                CFG_DECIMATE_ENABLE: decimate_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Mode choice at frame start: floor(len/5) >= cols is len >= 5*cols
    always_comb
    begin
        cols_cfg  = (display_width_reg > COLS_W'(MAX_COLUMNS)) ? COLS_W'(MAX_COLUMNS)
                                                               : display_width_reg;
        five_cols = {cols_cfg, 2'b00} + (COLS_W+3)'(cols_cfg);
        env_pick  = decimate_enable_reg && (cols_cfg != '0)
                    && (LEN_W'(five_cols) <= window_length_reg);
    end

    // Per-sample evaluation
    always_comb
    begin
        in_frame    = frame_open_reg && (sample_index_reg < IDX_W'(MAX_FRAME_SAMPLES));
        idx_ext     = SUM_W'(sample_index_reg);
        start_ext   = SUM_W'(f_start_reg);
        pass_end    = start_ext + SUM_W'(f_len_reg);
        win_end     = pass_end - SUM_W'(1);
        in_env_win  = (idx_ext >= start_ext) && (idx_ext <= win_end);
        in_pass_win = (idx_ext >= start_ext) && (idx_ext <= pass_end);
        max_upd     = (sample_reg > running_max_reg) ? sample_reg : running_max_reg;
        min_upd     = (sample_reg < running_min_reg) ? sample_reg : running_min_reg;
        count_upd   = bucket_count_reg + LEN_W'(1);
        more_cols   = (column_index_reg + COLS_W'(1)) < f_cols_reg;

        emit        = 1'b0;
        emit_column = '0;
        emit_high   = sample_reg;
        emit_low    = sample_reg;
        emit_env    = env_active_reg;
        emit_last   = 1'b0;
        if (state_reg == ST_PROCESS && in_frame)
        begin
            if (env_active_reg)
            begin
                emit_high = max_upd;
                emit_low  = min_upd;
                if (in_env_win && more_cols && count_upd >= bucket_length_reg)
                begin
                    emit        = 1'b1;
                    emit_column = COL_W'(column_index_reg);
                end
                else if (in_env_win && idx_ext == win_end)
                begin
                    emit        = 1'b1;
                    emit_column = COL_W'(f_cols_reg - COLS_W'(1));
                    emit_last   = 1'b1;
                end
            end
            else if (in_pass_win)
            begin
                emit        = 1'b1;
                emit_column = COL_W'(idx_ext - start_ext);
                emit_last   = (idx_ext == pass_end);
            end
        end
        stall = emit && out_valid_reg && !results.ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (samples.frame_start && env_pick) ? ST_DIVIDE : ST_PROCESS;
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                    state_next = ST_PROCESS;
            end
            ST_PROCESS:
            begin
                if (!stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        samples.ready    = (state_reg == ST_IDLE);
        div_req.start    = (state_reg == ST_IDLE) && samples.valid
                           && samples.frame_start && env_pick;
        div_req.dividend = window_length_reg;
        div_req.divisor  = cols_cfg;
    end

    // Datapath updates
    always_comb
    begin
        frame_open_next    = frame_open_reg;
        env_active_next    = env_active_reg;
        f_start_next       = f_start_reg;
        f_len_next         = f_len_reg;
        f_cols_next        = f_cols_reg;
        bucket_length_next = bucket_length_reg;
        bucket_count_next  = bucket_count_reg;
        column_index_next  = column_index_reg;
        sample_index_next  = sample_index_reg;
        running_max_next   = running_max_reg;
        running_min_next   = running_min_reg;
        sample_next        = sample_reg;

        // Take a request; a frame start latches the window and restarts the frame
        if (accept)
        begin
            sample_next = samples.sample;
            if (samples.frame_start)
            begin
                f_start_next       = window_start_reg;
                f_len_next         = window_length_reg;
                f_cols_next        = cols_cfg;
                env_active_next    = env_pick;
                bucket_length_next = '0;
                column_index_next  = '0;
                bucket_count_next  = '0;
                running_max_next   = SAMPLE_MIN;
                running_min_next   = SAMPLE_MAX;
                sample_index_next  = '0;
                frame_open_next    = 1'b1;
            end
        end

        // Bucket length from the divider
        if (state_reg == ST_DIVIDE && div_rsp.done)
            bucket_length_next = div_rsp.quotient;

        // Work on the held sample
        if (state_reg == ST_PROCESS && in_frame && !stall)
        begin
            sample_index_next = sample_index_reg + IDX_W'(1);
            if (env_active_reg && in_env_win)
            begin
                running_max_next  = max_upd;
                running_min_next  = min_upd;
                bucket_count_next = count_upd;
                if (emit)
                begin
                    running_max_next  = SAMPLE_MIN;
                    running_min_next  = SAMPLE_MAX;
                    bucket_count_next = '0;
                    if (!emit_last)
                        column_index_next = column_index_reg + COLS_W'(1);
                end
            end
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_column_next = out_column_reg;
        out_high_next   = out_high_reg;
        out_low_next    = out_low_reg;
        out_env_next    = out_env_reg;
        out_last_next   = out_last_reg;
        if (results.ready)
            out_valid_next = 1'b0;
        if (emit && !stall)
        begin
            out_valid_next  = 1'b1;
            out_column_next = emit_column;
            out_high_next   = emit_high;
            out_low_next    = emit_low;
            out_env_next    = emit_env;
            out_last_next   = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            frame_open_reg    <= 1'b0;
            env_active_reg    <= 1'b0;
            f_start_reg       <= '0;
            f_len_reg         <= '0;
            f_cols_reg        <= '0;
            bucket_length_reg <= '0;
            bucket_count_reg  <= '0;
            column_index_reg  <= '0;
            sample_index_reg  <= '0;
            running_max_reg   <= SAMPLE_MIN;
            running_min_reg   <= SAMPLE_MAX;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            frame_open_reg    <= frame_open_next;
            env_active_reg    <= env_active_next;
            f_start_reg       <= f_start_next;
            f_len_reg         <= f_len_next;
            f_cols_reg        <= f_cols_next;
            bucket_length_reg <= bucket_length_next;
            bucket_count_reg  <= bucket_count_next;
            column_index_reg  <= column_index_next;
            sample_index_reg  <= sample_index_next;
            running_max_reg   <= running_max_next;
            running_min_reg   <= running_min_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        out_column_reg <= out_column_next;
        out_high_reg   <= out_high_next;
        out_low_reg    <= out_low_next;
        out_env_reg    <= out_env_next;
        out_last_reg   <= out_last_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.column        = out_column_reg;
    assign results.high_value    = out_high_reg;
    assign results.low_value     = out_low_reg;
    assign results.envelope_mode = out_env_reg;
    assign results.last          = out_last_reg;

endmodule
